### rtl/cfi_pkg.sv
// Shared types, constants and tables for the flash command state machine.
package cfi_pkg;

	localparam int ARRAY_WORDS  = 4096;
	localparam int SECTOR_WORDS = 256;
	localparam int BUFFER_WORDS = 16;
	localparam int QUERY_WORDS  = 128;
	localparam int NUM_SECTORS  = (ARRAY_WORDS + SECTOR_WORDS - 1) / SECTOR_WORDS;

	localparam int AW = $clog2(ARRAY_WORDS);
	localparam int SW = $clog2(SECTOR_WORDS);
	localparam int BW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
	localparam int NW = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
	localparam int CW = $clog2(BUFFER_WORDS + 1);
	localparam int EW = $clog2(ARRAY_WORDS + 1);

	typedef enum logic [1:0] {
		RM_ARRAY  = 2'd0,
		RM_ID     = 2'd1,
		RM_STATUS = 2'd2,
		RM_QUERY  = 2'd3
	} rmode_t;

	localparam logic [7:0] CODE_CONFIRM   = 8'hD0;
	localparam logic [7:0] CODE_LOCK_SET  = 8'h01;
	localparam logic [7:0] CODE_READ_ARR  = 8'hFF;
	localparam logic [7:0] CODE_READ_ID   = 8'h90;
	localparam logic [7:0] CODE_READ_STAT = 8'h70;
	localparam logic [7:0] CODE_QUERY     = 8'h98;
	localparam logic [7:0] CODE_CLR_STAT  = 8'h50;
	localparam logic [7:0] CODE_PROG_A    = 8'h40;
	localparam logic [7:0] CODE_PROG_B    = 8'h10;
	localparam logic [7:0] CODE_BUFFER    = 8'hE8;
	localparam logic [7:0] CODE_ERASE     = 8'h20;
	localparam logic [7:0] CODE_LOCK      = 8'h60;

	localparam logic [31:0] ID_MAKER  = 32'h0089_0089;
	localparam logic [31:0] ID_DEVICE = 32'h0018_0018;
	localparam logic [31:0] ONES      = 32'hffff_ffff;

	// Error bits of the status register.
	localparam int E_PROT = 0;
	localparam int E_VOLT = 1;
	localparam int E_PGM  = 2;
	localparam int E_ERS  = 3;

	// Datapath operation chosen by the controller.
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_READ    = 4'd1,
		OP_PROGRAM = 4'd2,
		OP_BUF_CLR = 4'd3,
		OP_BUF_LD  = 4'd4,
		OP_BUF_RD  = 4'd5,
		OP_BUF_AND = 4'd6,
		OP_ERASE   = 4'd7,
		OP_FETCH   = 4'd8
	} op_t;

	typedef struct packed {
		op_t          op;
		logic [AW-1:0] addr;
		logic [31:0]  data;
		logic [BW-1:0] slot;
		logic         last;
	} dp_cmd_t;

	typedef struct packed {
		logic        rd_valid;
		logic [31:0] rd_data;
	} dp_stat_t;

	function automatic logic [NW-1:0] sector_of(input logic [AW:0] a);
		logic [AW:0] s;
		s = a >> SW;
		if (s >= (AW+1)'(NUM_SECTORS)) s = (AW+1)'(NUM_SECTORS - 1);
		return s[NW-1:0];
	endfunction

	function automatic logic [31:0] both_halves(input logic [15:0] v);
		return {v, v};
	endfunction

	function automatic logic [31:0] query_rom(input logic [6:0] a);
		logic [15:0] h;
		unique case (a)
			7'h00: h = 16'h0089; 7'h01: h = 16'h0018; 7'h02: h = 16'h0001;
			7'h10: h = 16'h0051; 7'h11: h = 16'h0052; 7'h12: h = 16'h0059;
			7'h13: h = 16'h0001; 7'h15: h = 16'h0031; 7'h1b: h = 16'h0027;
			7'h1c: h = 16'h0036; 7'h1f: h = 16'h0007; 7'h20: h = 16'h0007;
			7'h21: h = 16'h000A; 7'h23: h = 16'h0004; 7'h24: h = 16'h0004;
			7'h25: h = 16'h0004; 7'h27: h = 16'h0018; 7'h28: h = 16'h0002;
			7'h2a: h = 16'h0005; 7'h2c: h = 16'h0001; 7'h2d: h = 16'h007F;
			7'h30: h = 16'h0002; 7'h31: h = 16'h0050; 7'h32: h = 16'h0052;
			7'h33: h = 16'h0049; 7'h34: h = 16'h0031; 7'h35: h = 16'h0032;
			7'h36: h = 16'h00CE; 7'h3a: h = 16'h0001; 7'h3b: h = 16'h0001;
			7'h3c: h = 16'h0001; 7'h3d: h = 16'h0033; 7'h3f: h = 16'h0001;
			7'h41: h = 16'h0001; 7'h42: h = 16'h0003; 7'h43: h = 16'h0003;
			7'h44: h = 16'h0003;
			default: h = 16'h0000;
		endcase
		return {h, h};
	endfunction

endpackage

### rtl/cfi_ram.sv
// Generic RAM with one write port and one registered read port.
module cfi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/cfi_datapath.sv
// Datapath: flash array and write buffer memories with their read paths.
module cfi_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  cfi_pkg::dp_cmd_t  cmd,
	output cfi_pkg::dp_stat_t stat
);
	import cfi_pkg::*;

	logic          arr_we, buf_we;
	logic [AW-1:0] arr_wa, arr_ra;
	logic [31:0]   arr_wd, arr_rd, buf_wd, buf_rd;
	logic [BW-1:0] buf_wa, buf_ra;
	logic [AW-1:0] and_addr_q;
	logic          and_pend_q, rd_pend_q;

	// Array and buffer ports: reads, word program, erase sweep, buffer clear and load, and buffer merge.
	always_comb begin
		arr_we = 1'b0;
		arr_wa = cmd.addr;
		arr_wd = cmd.data;
		arr_ra = cmd.addr;
		buf_we = 1'b0;
		buf_wa = cmd.slot;
		buf_wd = cmd.data;
		buf_ra = cmd.slot;
		unique case (cmd.op)
			OP_PROGRAM: begin
				arr_we = 1'b1;
				arr_wd = cmd.data;
			end
			OP_ERASE: begin
				arr_we = 1'b1;
				arr_wd = ONES;
			end
			OP_BUF_CLR: begin
				buf_we = 1'b1;
				buf_wd = ONES;
			end
			OP_BUF_LD: buf_we = 1'b1;
			default: ;
		endcase
		if (and_pend_q) begin
			arr_we = 1'b1;
			arr_wa = and_addr_q;
			arr_wd = arr_rd & buf_rd;
		end
	end

	// Track the read issued last cycle for merge and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			and_pend_q <= 1'b0;
			rd_pend_q  <= 1'b0;
		end else begin
			and_pend_q <= (cmd.op == OP_BUF_AND);
			rd_pend_q  <= (cmd.op == OP_READ);
		end
	end

	always_ff @(posedge clk) begin
		and_addr_q <= cmd.addr;
	end

	assign stat.rd_valid = rd_pend_q;
	assign stat.rd_data  = arr_rd;

	cfi_ram #(.WIDTH(32), .DEPTH(ARRAY_WORDS)) u_array (
		.clk(clk), .we(arr_we), .waddr(arr_wa), .wdata(arr_wd),
		.raddr(arr_ra), .rdata(arr_rd)
	);

	cfi_ram #(.WIDTH(32), .DEPTH(1 << BW)) u_buffer (
		.clk(clk), .we(buf_we), .waddr(buf_wa), .wdata(buf_wd),
		.raddr(buf_ra), .rdata(buf_rd)
	);
endmodule

### rtl/cfi_ctrl.sv
// Controller: command decoding, sequence state, locks, status and sweeps.
module cfi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              command,
	input  logic [11:0]       word_address,
	input  logic [31:0]       write_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	output logic              busy,
	output logic              done,
	output logic [31:0]       read_data,
	output cfi_pkg::dp_cmd_t  cmd,
	input  cfi_pkg::dp_stat_t stat
);
	import cfi_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_PREP  = 8'b00000010,
		S_RDW   = 8'b00000100,
		S_CLR   = 8'b00001000,
		S_ERASE = 8'b00010000,
		S_MERGE = 8'b00100000,
		S_DONE  = 8'b01000000,
		S_INIT  = 8'b10000000
	} state_t;

	typedef enum logic [2:0] {
		SQ_READY = 3'd0, SQ_PROG = 3'd1, SQ_BUF = 3'd2, SQ_ERASE = 3'd3,
		SQ_LOCK = 3'd4
	} seq_t;

	state_t           state_q;
	seq_t             seq_q;
	rmode_t           rmode_q;
	logic [3:0]       err_q;
	logic [NUM_SECTORS-1:0] locks_q;
	logic             pen_q;
	logic [CW-1:0]    bcount_q, bloaded_q;
	logic [AW-1:0]    bstart_q, blatch_q;
	logic [EW-1:0]    idx_q;
	logic [AW-1:0]    a_q;
	logic [31:0]      d_q;
	logic [31:0]      other_q;
	logic             from_arr_q;
	logic             command_q;
	logic [7:0]       code;
	logic [AW:0]      end_addr;
	logic [8:0]       cnt_new;
	logic [EW-1:0]    sweep_a;
	logic [7:0]       st;
	logic [31:0]      prep_word;

	assign code = d_q[7:0];
	assign busy = (state_q != S_IDLE);
	assign cnt_new = {1'b0, d_q[7:0]} + 9'd1;
	assign end_addr = (AW+1)'({1'b0, a_q}) + (AW+1)'(cnt_new) - (AW+1)'(1);
	assign sweep_a = EW'(bstart_q) + idx_q;
	assign st = {2'b10, err_q[E_ERS], err_q[E_PGM], err_q[E_VOLT], 1'b0,
		err_q[E_PROT], 1'b0};

	// Datapath command for this cycle.
	always_comb begin
		cmd.op   = OP_NONE;
		cmd.addr = a_q;
		cmd.data = d_q;
		cmd.slot = a_q[BW-1:0];
		cmd.last = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.op = OP_ERASE;
				cmd.addr = idx_q[AW-1:0];
			end
			S_PREP: begin
				if (command_q || rmode_q == RM_ARRAY) cmd.op = OP_READ;
			end
			S_RDW: begin
				if (command_q) begin
					if (seq_q == SQ_BUF) cmd.op = OP_BUF_LD;
					else begin
						cmd.op = OP_PROGRAM;
						cmd.data = d_q & stat.rd_data;
					end
				end
			end
			S_CLR: begin
				cmd.op = OP_BUF_CLR;
				cmd.slot = idx_q[BW-1:0];
			end
			S_ERASE: begin
				cmd.op = OP_ERASE;
				cmd.addr = AW'({sector_of({1'b0, a_q}), {SW{1'b0}}}) + AW'(idx_q);
			end
			S_MERGE: begin
				cmd.op = (sweep_a < EW'(ARRAY_WORDS) && idx_q < EW'(BUFFER_WORDS))
					? OP_BUF_AND : OP_NONE;
				cmd.addr = sweep_a[AW-1:0];
				cmd.slot = sweep_a[BW-1:0];
			end
			default: ;
		endcase
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			seq_q      <= SQ_READY;
			rmode_q    <= RM_ARRAY;
			err_q      <= '0;
			locks_q    <= '0;
			pen_q      <= 1'b1;
			bcount_q   <= '0;
			bloaded_q  <= '0;
			bstart_q   <= '0;
			blatch_q   <= '0;
			idx_q      <= '0;
			done       <= 1'b0;
			command_q  <= 1'b0;
			from_arr_q <= 1'b0;
		end else begin
			done <= (state_q == S_DONE);
			if (cfg_we) pen_q <= cfg_wdata;
			unique case (state_q)
				S_INIT: begin
					idx_q <= idx_q + EW'(1);
					if (idx_q == EW'(ARRAY_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						command_q <= command;
						state_q   <= S_PREP;
					end
				end
				S_PREP: begin
					idx_q <= '0;
					if (!command_q) begin
						state_q <= (rmode_q == RM_ARRAY) ? S_RDW : S_DONE;
						from_arr_q <= (rmode_q == RM_ARRAY);
					end else begin
						from_arr_q <= 1'b0;
						unique case (seq_q)
							SQ_READY: begin
								state_q <= (code == CODE_BUFFER) ? S_CLR : S_DONE;
								priority case (code)
									CODE_READ_ARR:  rmode_q <= RM_ARRAY;
									CODE_READ_ID:   rmode_q <= RM_ID;
									CODE_READ_STAT: rmode_q <= RM_STATUS;
									CODE_QUERY:     rmode_q <= RM_QUERY;
									CODE_CLR_STAT: begin
										err_q <= '0;
										rmode_q <= RM_ARRAY;
									end
									CODE_PROG_A, CODE_PROG_B: seq_q <= SQ_PROG;
									CODE_BUFFER: begin
										seq_q <= SQ_BUF;
										rmode_q <= RM_STATUS;
										bcount_q <= '0;
										bloaded_q <= '0;
									end
									CODE_ERASE: seq_q <= SQ_ERASE;
									CODE_LOCK:  seq_q <= SQ_LOCK;
									default: ;
								endcase
							end
							SQ_PROG: begin
								rmode_q <= RM_STATUS;
								seq_q <= SQ_READY;
								if (locks_q[sector_of({1'b0, a_q})]) begin
									err_q[E_PGM] <= 1'b1; err_q[E_PROT] <= 1'b1;
									state_q <= S_DONE;
								end else if (!pen_q) begin
									err_q[E_PGM] <= 1'b1; err_q[E_VOLT] <= 1'b1;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RDW;
								end
							end
							SQ_ERASE: begin
								seq_q <= SQ_READY;
								if (code == CODE_CONFIRM) begin
									rmode_q <= RM_STATUS;
									if (locks_q[sector_of({1'b0, a_q})]) begin
										err_q[E_ERS] <= 1'b1; err_q[E_PROT] <= 1'b1;
										state_q <= S_DONE;
									end else if (!pen_q) begin
										err_q[E_ERS] <= 1'b1; err_q[E_VOLT] <= 1'b1;
										state_q <= S_DONE;
									end else state_q <= S_ERASE;
								end else state_q <= S_DONE;
							end
							SQ_LOCK: begin
								seq_q <= SQ_READY;
								state_q <= S_DONE;
								if (code == CODE_LOCK_SET) begin
									rmode_q <= RM_STATUS;
									if (!pen_q) begin
										err_q[E_PGM] <= 1'b1; err_q[E_VOLT] <= 1'b1;
									end else locks_q[sector_of({1'b0, a_q})] <= 1'b1;
								end else if (code == CODE_CONFIRM) begin
									rmode_q <= RM_STATUS;
									if (!pen_q) begin
										err_q[E_ERS] <= 1'b1; err_q[E_VOLT] <= 1'b1;
									end else locks_q <= '0;
								end
							end
							SQ_BUF: begin
								if (bcount_q == '0) begin
									state_q <= S_DONE;
									bcount_q <= CW'(cnt_new > 9'(BUFFER_WORDS) ?
										9'(BUFFER_WORDS) : cnt_new);
									blatch_q <= a_q;
									if (cnt_new > 9'(BUFFER_WORDS) ||
										sector_of({1'b0, a_q}) != sector_of(end_addr)) begin
										err_q[E_PGM] <= 1'b1; err_q[E_ERS] <= 1'b1;
										seq_q <= SQ_READY;
									end
								end else if (bloaded_q < bcount_q) begin
									if (sector_of({1'b0, a_q}) !=
										sector_of({1'b0, blatch_q})) begin
										err_q[E_PGM] <= 1'b1; err_q[E_ERS] <= 1'b1;
										seq_q <= SQ_READY;
										state_q <= S_DONE;
									end else begin
										if (bloaded_q == '0) bstart_q <= a_q;
										bloaded_q <= bloaded_q + CW'(1);
										state_q <= S_RDW;
									end
								end else begin
									seq_q <= SQ_READY;
									if (code != CODE_CONFIRM) begin
										err_q[E_PGM] <= 1'b1; err_q[E_ERS] <= 1'b1;
										state_q <= S_DONE;
									end else begin
										rmode_q <= RM_STATUS;
										if (locks_q[sector_of({1'b0, blatch_q})]) begin
											err_q[E_PGM] <= 1'b1; err_q[E_PROT] <= 1'b1;
											state_q <= S_DONE;
										end else if (!pen_q) begin
											err_q[E_PGM] <= 1'b1; err_q[E_VOLT] <= 1'b1;
											state_q <= S_DONE;
										end else state_q <= S_MERGE;
									end
								end
							end
							default: begin
								seq_q <= SQ_READY;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RDW: state_q <= S_DONE;
				S_CLR: begin
					idx_q <= idx_q + EW'(1);
					if (idx_q == EW'((1 << BW) - 1)) state_q <= S_DONE;
				end
				S_ERASE: begin
					idx_q <= idx_q + EW'(1);
					if (idx_q == EW'(SECTOR_WORDS - 1)) state_q <= S_DONE;
				end
				S_MERGE: begin
					idx_q <= idx_q + EW'(1);
					if (idx_q == EW'(BUFFER_WORDS)) state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Word for reads outside array mode; zero for writes.
	always_comb begin
		prep_word = '0;
		if (!command_q) begin
			unique case (rmode_q)
				RM_ID: begin
					if (a_q[SW-1:0] == SW'(0)) prep_word = ID_MAKER;
					else if (a_q[SW-1:0] == SW'(1)) prep_word = ID_DEVICE;
					else if (a_q[SW-1:0] == SW'(2))
						prep_word = both_halves({15'd0,
							locks_q[sector_of({1'b0, a_q})]});
				end
				RM_STATUS: prep_word = both_halves({8'd0, st});
				RM_QUERY: if ({1'b0, a_q} < (AW+1)'(QUERY_WORDS))
					prep_word = query_rom(a_q[6:0]);
				default: ;
			endcase
		end
	end

	// Capture the beat and hold the result word.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			a_q <= word_address[AW-1:0];
			d_q <= write_data;
		end
		if (state_q == S_PREP) other_q <= prep_word;
		else if (stat.rd_valid && from_arr_q) other_q <= stat.rd_data;
	end

	assign read_data = other_q;
endmodule

### rtl/cfi_flash_command_state_machine_unit.sv
// Top level of the flash command state machine; one beat is in flight at a time.
// done rises after the PREP and DONE states for commands and non-array reads, with RDW between
// them for array reads, word program and buffer loads; a new beat is taken in the done cycle.
// Block erase, write buffer setup and buffer confirm sweep in ERASE, CLR, MERGE (one word a cycle).
// Results show on done for one cycle; the receiver cannot stall.
// Reset clears control state, then a pass over every word fills the array with ones, busy high.
module cfi_flash_command_state_machine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        command,
	input  logic [11:0] word_address,
	input  logic [31:0] write_data,
	output logic [31:0] read_data,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import cfi_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cfi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.word_address(word_address), .write_data(write_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .busy(busy), .done(done),
		.read_data(read_data), .cmd(cmd), .stat(stat)
	);

	cfi_datapath u_dp (.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat));
endmodule

### rtl/cfi_checker.sv
// Port checker for the flash command state machine, bound to the top level.
module cfi_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	// An accepted beat makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after accept");

	// A result ends the busy period.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy while result shown");

	// A result lasts one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result longer than one cycle");

	// A result only follows a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a busy period");
endmodule

bind cfi_flash_command_state_machine_unit cfi_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);
